### hw/rtl/demand_paging_lru_translate_top_assert.svh
// assertion macros used by dplt_ctrl
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef DEMAND_PAGING_LRU_TRANSLATE_TOP_ASSERT_SVH
`define DEMAND_PAGING_LRU_TRANSLATE_TOP_ASSERT_SVH

// same-cycle implication, off while in reset
`define DPLT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dplt assertion failed");

// next-cycle implication, off while in reset
`define DPLT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dplt assertion failed");

`endif

### hw/rtl/dplt_pkg.sv
// types and constants of the paging translator
// used by dplt_cell, dplt_ctrl and demand_paging_lru_translate_top
package dplt_pkg;

    localparam int ADDR_W      = 12;
    localparam int PADDR_W     = 10;
    localparam int OFFSET_BITS = 7;
    localparam int PAGE_BITS   = 5;
    localparam int STAMP_W     = 32;
    localparam int COUNT_W     = 32;
    // frame 0 is reserved, frames 1..NUM_FRAMES-1 sit in the chain
    localparam int NUM_FRAMES  = 8;
    // frame index field, as wide as the frame field of the physical address
    localparam int FIDX_W      = $clog2(NUM_FRAMES);

    typedef logic [FIDX_W-1:0]    t_fidx;
    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [STAMP_W-1:0]   t_stamp;

    // search result handed from cell to cell
    typedef struct packed {
        logic   hit;
        t_fidx  hit_idx;
        logic   free_found;
        t_fidx  free_idx;
        t_stamp best_stamp;
        t_fidx  best_idx;
    } t_carry;

    // frame update broadcast to all cells
    typedef struct packed {
        logic   we;
        t_fidx  idx;
        t_page  owner;
        t_stamp stamp;
    } t_frame_wr;

    // chain head: nothing found yet, lru default is frame 1
    localparam t_carry CARRY_INIT = '{
        hit:        1'b0,
        hit_idx:    '0,
        free_found: 1'b0,
        free_idx:   '0,
        best_stamp: '1,
        best_idx:   t_fidx'(1)
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

endpackage

### hw/rtl/dplt_cell.sv
// one frame cell: owner page, in-use flag and last-use stamp
// merges its frame into the passing search result; depends on dplt_pkg
module dplt_cell
    import dplt_pkg::*;
#(
    parameter int CELL_IDX = 1
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_page     i_page,
    input  t_carry    i_carry,
    input  t_frame_wr i_wr,
    output t_carry    o_carry
);

    localparam t_fidx IDX = t_fidx'(CELL_IDX);

    logic   r_used;
    t_page  r_owner;
    t_stamp r_stamp;
    t_carry r_carry;
    t_carry n_carry;

    // frame state, written on a commit that selects this cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_stamp <= '0;
        end else if (i_wr.we && i_wr.idx == IDX) begin
            r_used  <= 1'b1;
            r_stamp <= i_wr.stamp;
        end
        if (i_wr.we && i_wr.idx == IDX) begin
            r_owner <= i_wr.owner;
        end
    end

    // merge this frame into the search result
    always_comb begin
        n_carry = i_carry;
        if (r_used && r_owner == i_page) begin
            n_carry.hit     = 1'b1;
            n_carry.hit_idx = IDX;
        end
        if (!r_used && !i_carry.free_found) begin
            n_carry.free_found = 1'b1;
            n_carry.free_idx   = IDX;
        end
        if (r_stamp < i_carry.best_stamp) begin
            n_carry.best_stamp = r_stamp;
            n_carry.best_idx   = IDX;
        end
    end

    // hand the result to the next cell
    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

    assign o_carry = r_carry;

endmodule

### hw/rtl/dplt_ctrl.sv
// sequencer: input transfer, scan wait, commit and result register
// also holds the access clock and fault counter; depends on dplt_pkg
`include "demand_paging_lru_translate_top_assert.svh"

module dplt_ctrl
    import dplt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [ADDR_W-1:0]  i_logical_address,
    input  t_carry             i_tail,
    output t_page              o_page,
    output t_frame_wr          o_wr,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [PADDR_W-1:0] o_physical_address,
    output logic               o_page_fault,
    output logic [COUNT_W-1:0] o_fault_count
);

    localparam int CW = $clog2(NUM_FRAMES);
    localparam int FBITS = PADDR_W - OFFSET_BITS;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_cnt, n_cnt;
    t_page                  r_page;
    logic [OFFSET_BITS-1:0] r_offset;
    t_stamp                 r_clock, n_clock;
    logic [COUNT_W-1:0]     r_faults, n_faults;
    logic                   r_out_valid, n_out_valid;
    logic [PADDR_W-1:0]     r_paddr;
    logic                   r_fault;
    logic                   in_xfer;
    logic                   commit_go;
    t_fidx                  frame;
    logic                   fault;

    assign in_xfer   = i_in_valid && (r_state == ST_IDLE);
    assign commit_go = (r_state == ST_COMMIT) && (!r_out_valid || i_out_ready);

    // frame choice from the chain tail: hit, lowest free, then lru
    always_comb begin
        fault = !i_tail.hit;
        if (i_tail.hit) begin
            frame = i_tail.hit_idx;
        end else if (i_tail.free_found) begin
            frame = i_tail.free_idx;
        end else begin
            frame = i_tail.best_idx;
        end
    end

    // next state, counters and output valid
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_clock     = r_clock;
        n_faults    = r_faults;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_SCAN;
                    n_cnt   = '0;
                end
            end
            ST_SCAN: begin
                if (r_cnt == CW'(NUM_FRAMES - 2)) begin
                    n_state = ST_COMMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_COMMIT: begin
                if (commit_go) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    if (r_clock != '1) begin
                        n_clock = r_clock + 1'b1;
                    end
                    if (fault && r_faults != '1) begin
                        n_faults = r_faults + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_clock     <= '0;
            r_faults    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_clock     <= n_clock;
            r_faults    <= n_faults;
            r_out_valid <= n_out_valid;
        end
    end

    // captured address and result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_page   <= i_logical_address[OFFSET_BITS +: PAGE_BITS];
            r_offset <= i_logical_address[OFFSET_BITS-1:0];
        end
        if (commit_go) begin
            r_paddr <= {frame[FBITS-1:0], r_offset};
            r_fault <= fault;
        end
    end

    // frame update broadcast, stamped with the advanced clock
    always_comb begin
        o_wr.we    = commit_go;
        o_wr.idx   = frame;
        o_wr.owner = r_page;
        o_wr.stamp = n_clock;
    end

    assign o_in_ready         = (r_state == ST_IDLE);
    assign o_page             = r_page;
    assign o_out_valid        = r_out_valid;
    assign o_physical_address = r_paddr;
    assign o_page_fault       = r_fault;
    assign o_fault_count      = r_faults;

    `DPLT_ASSERT_IMP(a_frame_in_range, o_wr.we, o_wr.idx != '0 && o_wr.idx < NUM_FRAMES)
    `DPLT_ASSERT_NXT(a_commit_shows, commit_go, r_out_valid)
    `DPLT_ASSERT_NXT(a_faults_grow, commit_go, r_faults >= $past(r_faults))

endmodule

### hw/rtl/demand_paging_lru_translate_top.sv
// Demand-paging address translator with LRU frame replacement.
// Input channel: i_in_valid / o_in_ready move one 12-bit logical address
// (page in bits 11..7, offset in bits 6..0). Output channel: o_out_valid /
// i_out_ready move the physical address (frame in bits 9..7, offset below),
// the page fault flag and the saturating fault count including this access.
// Frames sit in a chain of NUM_FRAMES-1 cells (frame 0 is reserved); a
// search result moves one cell per cycle through the chain, and a new
// address is taken only once the previous one has been committed.
// A hit reuses the owning frame; a miss takes the lowest free frame, else
// evicts the least recently stamped frame, lowest index on ties.
// Reset (i_rst_n low, synchronous) frees all frames and clears the access
// clock and fault count; no clearing pass follows.
// A result waits in the output register while i_out_ready is low; the next
// address is still taken and scanned, and its commit waits for the slot.
// Depends on dplt_pkg, dplt_cell and dplt_ctrl.
module demand_paging_lru_translate_top
    import dplt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [ADDR_W-1:0]  i_logical_address,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [PADDR_W-1:0] o_physical_address,
    output logic               o_page_fault,
    output logic [COUNT_W-1:0] o_fault_count
);

    t_carry    w_carry [NUM_FRAMES];
    t_page     w_page;
    t_frame_wr w_wr;

    // chain head
    assign w_carry[0] = CARRY_INIT;

    // one cell per usable frame
    for (genvar g = 1; g < NUM_FRAMES; g++) begin : g_cell
        dplt_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_page  (w_page),
            .i_carry (w_carry[g-1]),
            .i_wr    (w_wr),
            .o_carry (w_carry[g])
        );
    end

    // sequencer and result register
    dplt_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_logical_address  (i_logical_address),
        .i_tail             (w_carry[NUM_FRAMES-1]),
        .o_page             (w_page),
        .o_wr               (w_wr),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_physical_address (o_physical_address),
        .o_page_fault       (o_page_fault),
        .o_fault_count      (o_fault_count)
    );

endmodule

### test/demand_paging_lru_translate_top_test.sv
// self-checking testbench for the demand-paging translator with lru replacement
// holds its own page table and frame model and checks every result transfer
// depends on dplt_pkg and demand_paging_lru_translate_top
module demand_paging_lru_translate_top_test
    import dplt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES         = 8;
    localparam int FRAME_BITS     = 3;
    localparam int PAGES          = 32;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int HOLD_OFF_LONG  = 300;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [PADDR_W-1:0] phys;
        logic               fault;
        logic [COUNT_W-1:0] count;
    } t_translation;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [ADDR_W-1:0]  i_logical_address;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [PADDR_W-1:0] o_physical_address;
    logic               o_page_fault;
    logic [COUNT_W-1:0] o_fault_count;

    // page table and frame table of the predictor
    logic                  pg_valid [PAGES];
    logic [FRAME_BITS-1:0] pg_frame [PAGES];
    logic                  fr_free  [FRAMES];
    t_stamp                fr_stamp [FRAMES];
    t_page                 fr_owner [FRAMES];
    t_stamp                use_clock;
    logic [COUNT_W-1:0]    faults_seen;

    t_translation expected_translations[$];
    int           error_count;
    int           quiet_cycles;
    bit           idle_on;
    int           hold_request;

    demand_paging_lru_translate_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_logical_address  (i_logical_address),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_physical_address (o_physical_address),
        .o_page_fault       (o_page_fault),
        .o_fault_count      (o_fault_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic reset_page_tables();
        for (int p = 0; p < PAGES; p++) begin
            pg_valid[p] = 1'b0;
            pg_frame[p] = '0;
        end
        for (int f = 0; f < FRAMES; f++) begin
            fr_free[f]  = (f != 0);
            fr_stamp[f] = '0;
            fr_owner[f] = '0;
        end
        use_clock   = '0;
        faults_seen = '0;
    endtask

    // one access: hit reuses the frame, miss takes lowest free frame or evicts lru
    function automatic t_translation translate_address(input logic [ADDR_W-1:0] addr);
        t_page                 page;
        logic [FRAME_BITS-1:0] frame;
        t_stamp                oldest;
        bit                    got_free;
        t_translation          res;
        page      = addr[ADDR_W-1:OFFSET_BITS];
        res.fault = 1'b0;
        if (use_clock != '1) use_clock = use_clock + 1'b1;
        if (pg_valid[page]) begin
            frame = pg_frame[page];
        end else begin
            res.fault = 1'b1;
            if (faults_seen != '1) faults_seen = faults_seen + 1'b1;
            got_free = 1'b0;
            frame    = '0;
            // frame 0 is reserved, never free
            for (int f = 1; f < FRAMES; f++) begin
                if (!got_free && fr_free[f]) begin
                    got_free   = 1'b1;
                    frame      = FRAME_BITS'(f);
                    fr_free[f] = 1'b0;
                end
            end
            // no free frame: oldest stamp wins, strict compare keeps lowest index on ties
            if (!got_free) begin
                frame  = FRAME_BITS'(1);
                oldest = fr_stamp[1];
                for (int f = 2; f < FRAMES; f++) begin
                    if (fr_stamp[f] < oldest) begin
                        oldest = fr_stamp[f];
                        frame  = FRAME_BITS'(f);
                    end
                end
                pg_valid[fr_owner[frame]] = 1'b0;
            end
            pg_frame[page]  = frame;
            pg_valid[page]  = 1'b1;
            fr_owner[frame] = page;
        end
        fr_stamp[frame] = use_clock;
        res.phys  = {frame, addr[OFFSET_BITS-1:0]};
        res.count = faults_seen;
        return res;
    endfunction

    // offer one address, record its translation at the transfer
    task automatic send_address(input logic [ADDR_W-1:0] addr);
        int gap;
        bit in_fire;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_logical_address <= addr;
        do begin
            @(negedge i_clk);
            in_fire = o_in_ready;
            if (in_fire) expected_translations.push_back(translate_address(addr));
            @(posedge i_clk);
        end while (!in_fire);
    endtask

    // sender stops offering until every expected result has come
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_translations.size() != 0);
    endtask

    // compare one result transfer with the oldest expectation
    task automatic check_translation();
        t_translation want;
        if (expected_translations.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual phys %h fault %b count %0d",
                     $time, o_physical_address, o_page_fault, o_fault_count);
            error_count++;
        end else begin
            want = expected_translations.pop_front();
            if (o_physical_address !== want.phys) begin
                $display("%0t: physical_address expected %h actual %h",
                         $time, want.phys, o_physical_address);
                error_count++;
            end
            if (o_page_fault !== want.fault) begin
                $display("%0t: page_fault expected %b actual %b",
                         $time, want.fault, o_page_fault);
                error_count++;
            end
            if (o_fault_count !== want.count) begin
                $display("%0t: fault_count expected %0d actual %0d",
                         $time, want.count, o_fault_count);
                error_count++;
            end
        end
    endtask

    // result checker, sampled mid-cycle ahead of the transfer edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_translation();
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        int hold;
        int stall;
        bit out_fire;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                hold         = hold_request;
                hold_request = 0;
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end else begin
                stall = idle_on ? $urandom_range(0, 4) : 0;
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do begin
                @(negedge i_clk);
                out_fire = o_out_valid;
                @(posedge i_clk);
            end while (!out_fire);
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // cold fill of all frames, hits, then lru evictions and address extremes
    task automatic test_directed_extremes();
        logic [ADDR_W-1:0] seq [$];
        idle_on = 1'b1;
        seq = '{12'h000, 12'hFFF, 12'h07F, 12'hF80,
                {5'd5, 7'h11}, {5'd9, 7'h22}, {5'd14, 7'h33}, {5'd20, 7'h44},
                {5'd27, 7'h55},
                12'h040,
                {5'd1, 7'h01}, {5'd31, 7'h02}, {5'd5, 7'h03}, {5'd9, 7'h04},
                12'h000, 12'hAAA, 12'h555, 12'hAAA, 12'h555,
                {5'd16, 7'h7F}, {5'd16, 7'h00}, 12'hFFF};
        foreach (seq[k]) send_address(seq[k]);
    endtask

    // receiver holds off long while the sender keeps offering, then sender waits out
    task automatic test_output_backpressure();
        idle_on      = 1'b0;
        hold_request = HOLD_OFF_LONG;
        for (int n = 0; n < 24; n++) send_address(ADDR_W'($urandom));
        wait_for_drain();
        idle_on = 1'b1;
        for (int n = 0; n < 8; n++) send_address(ADDR_W'($urandom));
    endtask

    // mostly a shifting hot set of pages so hits and evictions both happen often
    task automatic test_random_locality(input int num_items);
        t_page             hot_pages [10];
        int                hot_size;
        logic [ADDR_W-1:0] addr;
        hot_size = 1;
        for (int n = 0; n < num_items; n++) begin
            if (n % 100 == 0) begin
                hot_size = $urandom_range(3, 10);
                foreach (hot_pages[k]) hot_pages[k] = t_page'($urandom);
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 9) < 7)
                addr = {hot_pages[$urandom_range(0, hot_size - 1)], OFFSET_BITS'($urandom)};
            else
                addr = ADDR_W'($urandom);
            send_address(addr);
        end
    endtask

    // main sequence
    initial begin
        error_count        = 0;
        hold_request       = 0;
        idle_on            = 1'b1;
        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_logical_address <= '0;
        reset_page_tables();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_output_backpressure();
        test_random_locality(RANDOM_ITEMS);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
